/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by perfect_gas_eos_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pgeos_pkg.sv */
// ----------------------------------------------------------------------------
// pgeos_pkg
// Shared widths, status codes and pipeline tag types of the gas EOS unit.
// ----------------------------------------------------------------------------
package pgeos_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC      = 16;
    localparam int GAMMA_W   = 19;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd91750;
    localparam logic [GAMMA_W-1:0] ONE_Q       = 19'd65536;

    // opcodes of the input transaction
    localparam logic OP_APPLY = 1'b0;
    localparam logic OP_INIT  = 1'b1;

    // divider lanes: 51-bit dividend, 35-bit divisor, one quotient bit per stage
    localparam int DIV_N_W   = 51;
    localparam int DIV_D_W   = 35;
    // square root: 68-bit radicand, 34-bit root, one root bit per stage
    localparam int SQ_X_W    = 68;
    localparam int SQ_ROOT_W = 34;
    localparam int SQ_REM_W  = 38;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic              op;
        logic              zero;
        logic              sat;
        logic [DATA_W-1:0] slope;
        logic [DATA_W-1:0] pressure;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [DIV_N_W-1:0] energy_q;
    } sq_tag_t;

endpackage

/* hdl/pgeos_div.sv */
// ----------------------------------------------------------------------------
// pgeos_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pgeos_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  pgeos_pkg::side_t              in_tag,
    input  logic [pgeos_pkg::DIV_N_W-1:0] a_num,
    input  logic [pgeos_pkg::DIV_D_W-1:0] a_den,
    input  logic [pgeos_pkg::DIV_N_W-1:0] b_num,
    input  logic [pgeos_pkg::DIV_D_W-1:0] b_den,
    output logic                          out_valid,
    output pgeos_pkg::side_t              out_tag,
    output logic [pgeos_pkg::DIV_N_W-1:0] a_quot,
    output logic [pgeos_pkg::DIV_N_W-1:0] b_quot
);

    localparam int NS = pgeos_pkg::DIV_N_W;

    typedef struct packed {
        logic [pgeos_pkg::DIV_N_W-1:0] n;
        logic [pgeos_pkg::DIV_N_W-1:0] q;
        logic [pgeos_pkg::DIV_D_W-1:0] r;
        logic [pgeos_pkg::DIV_D_W-1:0] d;
    } lane_t;

    function automatic lane_t div_step(lane_t x);
        lane_t                         y;
        logic [pgeos_pkg::DIV_D_W:0]   trial;
        logic                          ge;
        trial = {x.r, x.n[NS-1]};
        ge    = (trial >= {1'b0, x.d});
        y.d   = x.d;
        y.n   = {x.n[NS-2:0], 1'b0};
        y.q   = {x.q[NS-2:0], ge};
        y.r   = ge ? pgeos_pkg::DIV_D_W'(trial - {1'b0, x.d})
                   : trial[pgeos_pkg::DIV_D_W-1:0];
        return y;
    endfunction

    logic             valid_reg [1:NS];
    pgeos_pkg::side_t tag_reg   [1:NS];
    lane_t            a_reg     [1:NS];
    lane_t            b_reg     [1:NS];

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic             prev_valid;
        pgeos_pkg::side_t prev_tag;
        lane_t            prev_a;
        lane_t            prev_b;

        // first stage reads the ports
        if (k == 1) begin : g_first
            assign prev_valid = in_valid;
            assign prev_tag   = in_tag;
            assign prev_a     = '{n: a_num, q: '0, r: '0, d: a_den};
            assign prev_b     = '{n: b_num, q: '0, r: '0, d: b_den};
        end
        else begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_tag   = tag_reg[k-1];
            assign prev_a     = a_reg[k-1];
            assign prev_b     = b_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k] <= prev_tag;
                a_reg[k]   <= div_step(prev_a);
                b_reg[k]   <= div_step(prev_b);
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_tag   = tag_reg[NS];
    assign a_quot    = a_reg[NS].q;
    assign b_quot    = b_reg[NS].q;

endmodule

/* hdl/pgeos_sqrt.sv */
// ----------------------------------------------------------------------------
// pgeos_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pgeos_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  pgeos_pkg::sq_tag_t              in_tag,
    input  logic [pgeos_pkg::SQ_X_W-1:0]    radicand,
    output logic                            out_valid,
    output pgeos_pkg::sq_tag_t              out_tag,
    output logic [pgeos_pkg::SQ_ROOT_W-1:0] root
);

    localparam int NS = pgeos_pkg::SQ_ROOT_W;

    typedef struct packed {
        logic [pgeos_pkg::SQ_X_W-1:0]    x;
        logic [pgeos_pkg::SQ_REM_W-1:0]  rem;
        logic [pgeos_pkg::SQ_ROOT_W-1:0] root;
    } sq_t;

    function automatic sq_t sq_step(sq_t s);
        sq_t                            t;
        logic [pgeos_pkg::SQ_REM_W-1:0] rem2;
        logic [pgeos_pkg::SQ_REM_W-1:0] trial;
        logic                           ge;
        rem2   = {s.rem[pgeos_pkg::SQ_REM_W-3:0], s.x[pgeos_pkg::SQ_X_W-1 -: 2]};
        trial  = pgeos_pkg::SQ_REM_W'({s.root, 2'b01});
        ge     = (rem2 >= trial);
        t.x    = {s.x[pgeos_pkg::SQ_X_W-3:0], 2'b00};
        t.rem  = ge ? (rem2 - trial) : rem2;
        t.root = {s.root[NS-2:0], ge};
        return t;
    endfunction

    logic               valid_reg [1:NS];
    pgeos_pkg::sq_tag_t tag_reg   [1:NS];
    sq_t                st_reg    [1:NS];

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic               prev_valid;
        pgeos_pkg::sq_tag_t prev_tag;
        sq_t                prev_st;

        // first stage reads the ports
        if (k == 1) begin : g_first
            assign prev_valid = in_valid;
            assign prev_tag   = in_tag;
            assign prev_st    = '{x: radicand, rem: '0, root: '0};
        end
        else begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_tag   = tag_reg[k-1];
            assign prev_st    = st_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k] <= prev_tag;
                st_reg[k]  <= sq_step(prev_st);
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_tag   = tag_reg[NS];
    assign root      = st_reg[NS].root;

endmodule

/* hdl/perfect_gas_eos_unit.sv */
// ----------------------------------------------------------------------------
// perfect_gas_eos_unit
// Ideal-gas equation of state per cell, unsigned Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | in_valid / in_stall | opcode, density, second_value
//  out     | output    | out_valid/out_stall | derived_value, acoustic_speed,
//          |           |                     | pressure_slope, status
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (adiabatic index)
//
// One transaction per cycle sustained while out_stall does not hold the
// output register. The pipe has five front stages (two multiplies, two
// saturations, gamma*p), 51 divider stages, 34 square root stages and the
// output register. Depth is set by the bit-per-stage divider and square-root
// pipelines. The whole pipe advances together and holds when a result sits
// in the output register under out_stall; in_stall is raised in exactly those
// cycles. Reset clears valid bits and loads gamma = 1.4.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module perfect_gas_eos_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input transactions
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] density,
    input  logic [31:0] second_value,
    // result transactions
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] derived_value,
    output logic [31:0] acoustic_speed,
    output logic [31:0] pressure_slope,
    output logic [1:0]  status,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [18:0] cfg_data
);

    localparam int DW = pgeos_pkg::DATA_W;
    localparam int F  = pgeos_pkg::FRAC;
    localparam int GW = pgeos_pkg::GAMMA_W;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [GW-1:0] adiabatic_index_reg;
    logic [GW-1:0] g1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            adiabatic_index_reg <= pgeos_pkg::GAMMA_RESET;
        else if (cfg_valid && cfg_ready)
            adiabatic_index_reg <= cfg_data;
    end

    // gamma - 1, clamped at zero
    assign g1 = (adiabatic_index_reg > pgeos_pkg::ONE_Q)
              ? (adiabatic_index_reg - pgeos_pkg::ONE_Q) : '0;

    // global advance: everything moves unless the output is held
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // S1: register inputs, m1 = g1 * rho
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic             s1_op_reg;
    logic [DW-1:0]    s1_rho_reg, s1_v_reg;
    logic [GW+DW-1:0] s1_m1_reg;

    // S2: slope (saturated) and the raw init denominator
    logic             s2_valid_reg;
    logic             s2_op_reg;
    logic [DW-1:0]    s2_rho_reg, s2_v_reg, s2_slope_reg;
    logic             s2_slope_sat_reg;
    logic [pgeos_pkg::DIV_D_W-1:0] s2_den_reg;
    logic [pgeos_pkg::DIV_D_W-1:0] s1_den;

    // S3: m2 = slope * e
    logic             s3_valid_reg;
    logic             s3_op_reg;
    logic [DW-1:0]    s3_rho_reg, s3_v_reg, s3_slope_reg;
    logic             s3_slope_sat_reg;
    logic [pgeos_pkg::DIV_D_W-1:0] s3_den_reg;
    logic [2*DW-1:0]  s3_m2_reg;

    // S4: pressure selected and saturated
    logic             s4_valid_reg;
    logic             s4_op_reg;
    logic [DW-1:0]    s4_rho_reg, s4_v_reg, s4_slope_reg, s4_p_reg;
    logic             s4_sat_reg;
    logic [pgeos_pkg::DIV_D_W-1:0] s4_den_reg;
    logic [2*DW-F-1:0] s3_p_wide;
    logic             s3_p_sat;

    // S5: gamma * p, divider operands
    logic             s5_valid_reg;
    logic             s5_op_reg;
    logic [DW-1:0]    s5_rho_reg, s5_v_reg, s5_slope_reg, s5_p_reg;
    logic             s5_sat_reg;
    logic [pgeos_pkg::DIV_D_W-1:0] s5_den_reg;
    logic [GW+DW-1:0] s5_gp_reg;

    assign s1_den    = s1_m1_reg[GW+DW-1:F];
    assign s3_p_wide = s3_m2_reg[2*DW-1:F];
    assign s3_p_sat  = |s3_p_wide[2*DW-F-1:DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg  <= opcode;
            s1_rho_reg <= density;
            s1_v_reg   <= second_value;
            s1_m1_reg  <= g1 * density;

            s2_op_reg        <= s1_op_reg;
            s2_rho_reg       <= s1_rho_reg;
            s2_v_reg         <= s1_v_reg;
            s2_den_reg       <= s1_den;
            s2_slope_sat_reg <= |s1_den[pgeos_pkg::DIV_D_W-1:DW];
            s2_slope_reg     <= (|s1_den[pgeos_pkg::DIV_D_W-1:DW]) ? '1 : s1_den[DW-1:0];

            s3_op_reg        <= s2_op_reg;
            s3_rho_reg       <= s2_rho_reg;
            s3_v_reg         <= s2_v_reg;
            s3_den_reg       <= s2_den_reg;
            s3_slope_reg     <= s2_slope_reg;
            s3_slope_sat_reg <= s2_slope_sat_reg;
            s3_m2_reg        <= s2_slope_reg * s2_v_reg;

            s4_op_reg    <= s3_op_reg;
            s4_rho_reg   <= s3_rho_reg;
            s4_v_reg     <= s3_v_reg;
            s4_den_reg   <= s3_den_reg;
            s4_slope_reg <= s3_slope_reg;
            // init takes pressure as given; apply uses the saturated product
            s4_p_reg     <= (s3_op_reg == pgeos_pkg::OP_INIT) ? s3_v_reg
                          : (s3_p_sat ? '1 : s3_p_wide[DW-1:0]);
            s4_sat_reg   <= (s3_op_reg == pgeos_pkg::OP_APPLY)
                          && (s3_slope_sat_reg || s3_p_sat);

            s5_op_reg    <= s4_op_reg;
            s5_rho_reg   <= s4_rho_reg;
            s5_v_reg     <= s4_v_reg;
            s5_den_reg   <= s4_den_reg;
            s5_slope_reg <= s4_slope_reg;
            s5_p_reg     <= s4_p_reg;
            s5_sat_reg   <= s4_sat_reg;
            s5_gp_reg    <= adiabatic_index_reg * s4_p_reg;
        end
    end

    // ------------------------------------------------------------------
    // dividers: lane a = gamma*p / rho, lane b = (second_value << F) / den
    // ------------------------------------------------------------------
    pgeos_pkg::side_t              div_tag_in, div_tag_out;
    logic                          div_valid_out;
    logic [pgeos_pkg::DIV_N_W-1:0] sound_q, energy_q;

    assign div_tag_in = '{op:       s5_op_reg,
                          zero:     (s5_rho_reg == '0),
                          sat:      s5_sat_reg,
                          slope:    s5_slope_reg,
                          pressure: s5_p_reg};

    pgeos_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s5_valid_reg),
        .in_tag    (div_tag_in),
        .a_num     (s5_gp_reg),
        .a_den     (pgeos_pkg::DIV_D_W'(s5_rho_reg)),
        .b_num     (pgeos_pkg::DIV_N_W'({s5_v_reg, {F{1'b0}}})),
        .b_den     (s5_den_reg),
        .out_valid (div_valid_out),
        .out_tag   (div_tag_out),
        .a_quot    (sound_q),
        .b_quot    (energy_q)
    );

    // ------------------------------------------------------------------
    // square root of (gamma*p/rho) << F
    // ------------------------------------------------------------------
    pgeos_pkg::sq_tag_t              sq_tag_in, sq_tag_out;
    logic                            sq_valid_out;
    logic [pgeos_pkg::SQ_ROOT_W-1:0] sq_root;

    assign sq_tag_in = '{side: div_tag_out, energy_q: energy_q};

    pgeos_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_valid_out),
        .in_tag    (sq_tag_in),
        .radicand  (pgeos_pkg::SQ_X_W'({sound_q, {F{1'b0}}})),
        .out_valid (sq_valid_out),
        .out_tag   (sq_tag_out),
        .root      (sq_root)
    );

    // ------------------------------------------------------------------
    // output register: final saturation and status
    // ------------------------------------------------------------------
    logic             e_sat, c_sat, any_sat, is_init;
    logic [DW-1:0]    derived_next, sound_next, slope_next;
    pgeos_pkg::status_t status_next;
    logic [DW-1:0]    derived_reg, sound_reg, slope_reg;
    pgeos_pkg::status_t status_reg;

    always_comb
    begin
        is_init = (sq_tag_out.side.op == pgeos_pkg::OP_INIT);
        e_sat   = |sq_tag_out.energy_q[pgeos_pkg::DIV_N_W-1:DW];
        c_sat   = |sq_root[pgeos_pkg::SQ_ROOT_W-1:DW];
        any_sat = sq_tag_out.side.sat || c_sat || (is_init && e_sat);
        if (sq_tag_out.side.zero)
        begin
            derived_next = '0;
            sound_next   = '0;
            slope_next   = '0;
            status_next  = pgeos_pkg::STAT_ZERO;
        end
        else
        begin
            if (is_init)
                derived_next = e_sat ? '1 : sq_tag_out.energy_q[DW-1:0];
            else
                derived_next = sq_tag_out.side.pressure;
            sound_next  = c_sat ? '1 : sq_root[DW-1:0];
            slope_next  = is_init ? '0 : sq_tag_out.side.slope;
            status_next = any_sat ? pgeos_pkg::STAT_SAT : pgeos_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sq_valid_out;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            derived_reg <= derived_next;
            sound_reg   <= sound_next;
            slope_reg   <= slope_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign derived_value  = derived_reg;
    assign acoustic_speed = sound_reg;
    assign pressure_slope = slope_reg;
    assign status         = status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_zero_clears, out_valid && (status_reg == pgeos_pkg::STAT_ZERO),
        (derived_value == '0) && (acoustic_speed == '0) && (pressure_slope == '0),
        "zero density result carries nonzero fields")
    `ASSERT_IMPL(a_status_code, out_valid,
        (status_reg == pgeos_pkg::STAT_OK) || (status_reg == pgeos_pkg::STAT_ZERO)
        || (status_reg == pgeos_pkg::STAT_SAT),
        "undefined status code")
    `ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready,
        adiabatic_index_reg == $past(cfg_data),
        "adiabatic index not updated by configuration write")

endmodule
